// ===== design/acn_pkg.sv =====
// acn_pkg: shared types and constants for the alert notification block.
// Holds service state codes, config register indexes, controller states
// and the command/status structs between controller and datapath.
package acn_pkg;

	localparam int unsigned REG_BITS   = 16;
	localparam int unsigned INDEX_BITS = 3;
	localparam int unsigned IN_BITS    = 40;
	localparam int unsigned OUT_BITS   = 24;

	// service state encoding
	localparam logic [1:0] SVC_OK       = 2'd0;
	localparam logic [1:0] SVC_WARNING  = 2'd1;
	localparam logic [1:0] SVC_CRITICAL = 2'd2;

	// configuration register indexes
	localparam logic [INDEX_BITS-1:0] REG_HOLD_COUNT  = 3'd0;
	localparam logic [INDEX_BITS-1:0] REG_RENOTIFY    = 3'd1;
	localparam logic [INDEX_BITS-1:0] REG_ESCALATE    = 3'd2;
	localparam logic [INDEX_BITS-1:0] REG_PASSIVE_TMO = 3'd3;
	localparam logic [INDEX_BITS-1:0] REG_ACK_ENABLED = 3'd4;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_START_R,
		CS_WAIT_R,
		CS_START_E,
		CS_WAIT_E,
		CS_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic load;       // take the input word
		logic div_start;  // kick the remainder unit
		logic div_esc;    // 0: renotify interval, 1: escalation interval
		logic finish;     // commit state and load the output word
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

// ===== design/acn_rem.sv =====
// acn_rem: bit-serial restoring remainder unit, one dividend bit a cycle.
// Uses acn_pkg for the divisor width.
module acn_rem #(
	parameter int unsigned DIVIDEND_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [DIVIDEND_BITS-1:0]           dividend,
	input  logic [acn_pkg::REG_BITS-1:0]       divisor,
	output logic                               done,
	output logic [acn_pkg::REG_BITS-1:0]       remainder
);

	localparam int unsigned CW = $clog2(DIVIDEND_BITS + 1);
	localparam int unsigned RW = acn_pkg::REG_BITS;

	logic [DIVIDEND_BITS-1:0] dvd_q;
	logic [RW-1:0]            dsr_q;
	logic [RW-1:0]            rem_q;
	logic [CW-1:0]            step_q;
	logic                     done_q;
	logic [RW:0]              trial;
	logic [RW-1:0]            rem_next;

	always_comb begin
		trial = {rem_q, dvd_q[DIVIDEND_BITS-1]};
		if (trial >= {1'b0, dsr_q}) begin
			rem_next = RW'(trial - {1'b0, dsr_q});
		end else begin
			rem_next = trial[RW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (step_q == CW'(1));
			if (start) begin
				step_q <= CW'(DIVIDEND_BITS);
			end else if (step_q != '0) begin
				step_q <= step_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (step_q != '0) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== design/acn_dp.sv =====
// acn_dp: datapath - config registers, passive timeout rule, hold counter,
// announce/recovery/ack flags and the output word. Uses acn_pkg, acn_rem.
module acn_dp #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [acn_pkg::INDEX_BITS-1:0]     cfg_index,
	input  logic [acn_pkg::REG_BITS-1:0]       cfg_data,
	input  logic [acn_pkg::IN_BITS-1:0]        s_tdata,
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [acn_pkg::OUT_BITS-1:0]       m_tdata,
	input  acn_pkg::dp_cmd_t                   cmd,
	output acn_pkg::dp_status_t                sts
);

	localparam int unsigned RW    = acn_pkg::REG_BITS;
	localparam int unsigned CMP_W = (COUNT_BITS > RW) ? COUNT_BITS : RW;
	localparam int unsigned OUT_BITS_L = acn_pkg::OUT_BITS;

	logic [RW-1:0]         hold_q, renotify_q, escalate_q, timeout_q;
	logic                  ack_en_q;
	logic [1:0]            prev_q, ann_q, eff_q;
	logic                  changed_q, rec_q, ack_q, hit_r_q, hit_e_q, out_valid_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [OUT_BITS_L-1:0] out_q;

	logic [1:0]            meas;
	logic [31:0]           idle;
	logic [1:0]            eff_in;
	logic                  div_done;
	logic [RW-1:0]         rem;
	logic [RW-1:0]         divisor;
	logic [CMP_W-1:0]      cnt_ext, hold_ext;
	logic                  eq, held, crit, note, renote, esc;
	logic                  rec_next, ack_next;
	logic [1:0]            ann_next;

	assign meas = s_tdata[1:0];
	assign idle = s_tdata[33:2];

	// passive silence: warning at the timeout, critical at twice it
	always_comb begin
		eff_in = meas;
		if (s_tuser && timeout_q != '0 && idle >= 32'(timeout_q)) begin
			if ({1'b0, idle} >= 33'({timeout_q, 1'b0})) begin
				eff_in = acn_pkg::SVC_CRITICAL;
			end else begin
				eff_in = acn_pkg::SVC_WARNING;
			end
		end
	end

	assign divisor = cmd.div_esc ? escalate_q : renotify_q;

	acn_rem #(
		.DIVIDEND_BITS(COUNT_BITS)
	) u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (cnt_q),
		.divisor   (divisor),
		.done      (div_done),
		.remainder (rem)
	);

	always_comb begin
		cnt_ext  = CMP_W'(cnt_q);
		hold_ext = CMP_W'(hold_q);
		eq       = (cnt_ext == hold_ext);
		held     = (cnt_ext >= hold_ext);
		crit     = (eff_q == acn_pkg::SVC_CRITICAL);
		note     = eq && (eff_q != ann_q);
		renote   = held && crit && hit_r_q;
		esc      = held && crit && hit_e_q;
		rec_next = rec_q;
		ack_next = ack_q;
		ann_next = ann_q;
		if (note) begin
			ann_next = eff_q;
			if (crit) begin
				rec_next = 1'b1;
			end else if (eff_q == acn_pkg::SVC_OK) begin
				rec_next = 1'b0;
			end
			if (ack_en_q && crit) begin
				ack_next = 1'b1;
			end
		end
		if (renote) begin
			ann_next = eff_q;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q     <= '0;
			renotify_q <= '0;
			escalate_q <= '0;
			timeout_q  <= '0;
			ack_en_q   <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				acn_pkg::REG_HOLD_COUNT:  hold_q     <= cfg_data;
				acn_pkg::REG_RENOTIFY:    renotify_q <= cfg_data;
				acn_pkg::REG_ESCALATE:    escalate_q <= cfg_data;
				acn_pkg::REG_PASSIVE_TMO: timeout_q  <= cfg_data;
				acn_pkg::REG_ACK_ENABLED: ack_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// service state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= acn_pkg::SVC_OK;
			ann_q       <= acn_pkg::SVC_OK;
			cnt_q       <= '0;
			rec_q       <= 1'b0;
			ack_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && eff_in != prev_q) begin
				cnt_q  <= '0;
				prev_q <= eff_in;
			end else if (cmd.finish && cnt_q != '1) begin
				cnt_q <= cnt_q + COUNT_BITS'(1);
			end
			if (cmd.finish) begin
				ann_q       <= ann_next;
				rec_q       <= rec_next;
				ack_q       <= ack_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// per-word payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			eff_q     <= eff_in;
			changed_q <= (eff_in != prev_q);
		end
		if (div_done && !cmd.div_esc) begin
			hit_r_q <= (rem == '0) && (renotify_q != '0);
		end
		if (div_done && cmd.div_esc) begin
			hit_e_q <= (rem == '0) && (escalate_q != '0);
		end
		if (cmd.finish) begin
			out_q <= {cnt_ext[15:0], ack_next, rec_next, esc, renote, note,
				changed_q, eff_q};
		end
	end

	assign m_tvalid     = out_valid_q;
	assign m_tdata      = out_q;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || m_tready;

`ifndef ASSERT_OFF
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> m_tvalid)
		else $error("output word not raised after finish");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && eff_in != prev_q) |=> (cnt_q == '0 && changed_q))
		else $error("hold counter not restarted on state change");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && !cmd.load && cnt_q == '1) |=> cnt_q == '1)
		else $error("hold counter wrapped");
`endif

endmodule

// ===== design/acn_ctrl.sv =====
// acn_ctrl: controller state machine sequencing input take, two remainder
// runs and the commit of each word. Uses acn_pkg types.
module acn_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  acn_pkg::dp_status_t  sts,
	output acn_pkg::dp_cmd_t     cmd
);

	acn_pkg::ctrl_state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acn_pkg::CS_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			acn_pkg::CS_IDLE:    if (s_tvalid) state_next = acn_pkg::CS_START_R;
			acn_pkg::CS_START_R: state_next = acn_pkg::CS_WAIT_R;
			acn_pkg::CS_WAIT_R:  if (sts.div_done) state_next = acn_pkg::CS_START_E;
			acn_pkg::CS_START_E: state_next = acn_pkg::CS_WAIT_E;
			acn_pkg::CS_WAIT_E:  if (sts.div_done) state_next = acn_pkg::CS_DONE;
			acn_pkg::CS_DONE:    if (sts.out_free) state_next = acn_pkg::CS_IDLE;
			default:             state_next = acn_pkg::CS_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = 1'b0;
		cmd.load      = 1'b0;
		cmd.div_start = 1'b0;
		cmd.div_esc   = 1'b0;
		cmd.finish    = 1'b0;
		case (state_q)
			acn_pkg::CS_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			acn_pkg::CS_START_R: cmd.div_start = 1'b1;
			acn_pkg::CS_WAIT_R:  ;
			acn_pkg::CS_START_E: begin
				cmd.div_start = 1'b1;
				cmd.div_esc   = 1'b1;
			end
			acn_pkg::CS_WAIT_E:  cmd.div_esc = 1'b1;
			acn_pkg::CS_DONE:    cmd.finish = sts.out_free;
			default:             ;
		endcase
	end

`ifndef ASSERT_OFF
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> state_q == acn_pkg::CS_START_R)
		else $error("word taken without starting the remainder run");
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("commit while output word still held");
	a_start_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (state_q == acn_pkg::CS_WAIT_R || state_q == acn_pkg::CS_WAIT_E))
		else $error("remainder run started without waiting for it");
`endif

endmodule

// ===== design/alert_notify_state_machine.sv =====
// alert_notify_state_machine: top level; controller plus datapath.
// Each input word passes through two runs of the bit-serial remainder unit
// (renotify interval, then escalation interval) before its output word is loaded.
// Words are taken one at a time; a new word is taken
// while the previous result still waits in the output register.
// Reset (arst_n, async, active low) clears config, service state and handshakes.
module alert_notify_state_machine #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [acn_pkg::INDEX_BITS-1:0] cfg_index,
	input  logic [acn_pkg::REG_BITS-1:0]   cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [1:0] measured_state, [33:2] idle_seconds, [39:34] zero
	input  logic [acn_pkg::IN_BITS-1:0]    s_tdata,
	// [0] is_passive
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [1:0] effective_state, [2] state_changed, [3] notify, [4] renotify,
	// [5] escalate, [6] recovery_pending, [7] ack_pending, [23:8] hold_counter
	output logic [acn_pkg::OUT_BITS-1:0]   m_tdata
);

	acn_pkg::dp_cmd_t    cmd;
	acn_pkg::dp_status_t sts;

	acn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	acn_dp #(
		.COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== tb/sv/alert_notify_state_machine_tb.sv =====
// alert_notify_state_machine_tb: self-checking bench for the alert notification block.
// Drives check results over the input stream with random gaps and stalls, predicts every
// output word in-bench and compares field by field. Needs acn_pkg and the block only.
`timescale 1ns / 100ps

module alert_notify_state_machine_tb;

	localparam int unsigned LATENCY     = 2 * (16 + 1) + 4;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam logic [1:0] SVC_UNKNOWN  = 2'd3;
	localparam logic [acn_pkg::INDEX_BITS-1:0] REG_FIRST_UNUSED =
		acn_pkg::REG_ACK_ENABLED + 1'b1;
	localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

	// output word, lowest field last
	typedef struct packed {
		logic [15:0] hold_counter;
		logic        ack_pending;
		logic        recovery_pending;
		logic        escalate;
		logic        renotify;
		logic        notify;
		logic        state_changed;
		logic [1:0]  effective_state;
	} notice_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [acn_pkg::INDEX_BITS-1:0] cfg_index;
	logic [acn_pkg::REG_BITS-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [acn_pkg::IN_BITS-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [acn_pkg::OUT_BITS-1:0] m_tdata;

	// shadow configuration
	logic [15:0] hold_cfg, renotify_cfg, escalate_cfg, passive_tmo_cfg;
	logic        ack_en_cfg;
	// shadow service state
	logic [1:0]  prior_state, announced;
	logic [15:0] persist;
	logic        recovery, ack_flag;

	notice_t notices_due[$];
	int unsigned fails, checks_sent, reg_writes, settings_used;
	int unsigned notify_seen, renotify_seen, escalate_seen;
	int unsigned cycles;
	bit tx_gaps, rx_gaps;

	alert_notify_state_machine uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles,
				notices_due.size());
			$display("alert_notify_state_machine test failed");
			$finish;
		end
	end

	function automatic int unsigned short_or_long(input int unsigned zero_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < zero_pct)
			return 0;
		else if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 80);
	endfunction

	function automatic void clear_service_state();
		hold_cfg        = '0;
		renotify_cfg    = '0;
		escalate_cfg    = '0;
		passive_tmo_cfg = '0;
		ack_en_cfg      = 1'b0;
		prior_state     = acn_pkg::SVC_OK;
		announced       = acn_pkg::SVC_OK;
		persist         = '0;
		recovery        = 1'b0;
		ack_flag        = 1'b0;
	endfunction

	// next output word for one check result; advances the shadow state
	function automatic notice_t predict_notice(input logic [1:0] measured, input logic passive,
			input logic [31:0] idle);
		notice_t n;
		logic [1:0] eff;
		logic [32:0] twice_tmo;
		logic held, crit;
		n = '0;
		eff = measured;
		twice_tmo = {16'd0, passive_tmo_cfg, 1'b0};
		if (passive && passive_tmo_cfg != 0 && idle >= {16'd0, passive_tmo_cfg})
			eff = ({1'b0, idle} >= twice_tmo) ? acn_pkg::SVC_CRITICAL
				: acn_pkg::SVC_WARNING;
		n.state_changed = (eff != prior_state);
		if (n.state_changed) begin
			persist = '0;
			prior_state = eff;
		end
		if (persist == hold_cfg && eff != announced) begin
			n.notify = 1'b1;
			if (eff == acn_pkg::SVC_CRITICAL)
				recovery = 1'b1;
			announced = eff;
			if (eff == acn_pkg::SVC_OK)
				recovery = 1'b0;
			if (ack_en_cfg && eff == acn_pkg::SVC_CRITICAL)
				ack_flag = 1'b1;
		end
		held = (persist >= hold_cfg);
		crit = (eff == acn_pkg::SVC_CRITICAL);
		if (held && crit && renotify_cfg != 0 && persist % renotify_cfg == 0) begin
			n.renotify = 1'b1;
			announced = eff;
		end
		if (held && crit && escalate_cfg != 0 && persist % escalate_cfg == 0)
			n.escalate = 1'b1;
		n.effective_state  = eff;
		n.recovery_pending = recovery;
		n.ack_pending      = ack_flag;
		n.hold_counter     = persist;
		if (persist != COUNT_MAX)
			persist = persist + 1'b1;
		return n;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk) begin : check_notices
		notice_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = notice_t'(m_tdata);
			if (notices_due.size() == 0) begin
				$error("output word %h with no check result pending", m_tdata);
				fails++;
			end else begin
				want = notices_due.pop_front();
				check_field("effective_state", want.effective_state, got.effective_state);
				check_field("state_changed", want.state_changed, got.state_changed);
				check_field("notify", want.notify, got.notify);
				check_field("renotify", want.renotify, got.renotify);
				check_field("escalate", want.escalate, got.escalate);
				check_field("recovery_pending", want.recovery_pending, got.recovery_pending);
				check_field("ack_pending", want.ack_pending, got.ack_pending);
				check_field("hold_counter", want.hold_counter, got.hold_counter);
				notify_seen   += got.notify;
				renotify_seen += got.renotify;
				escalate_seen += got.escalate;
			end
		end
	end

	// output side back-pressure
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		m_tready <= 1'b1;
		forever begin
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(40, 120)
					: $urandom_range(1, 20)) @(posedge clk);
			if (rx_gaps) begin
				m_tready <= 1'b0;
				repeat (short_or_long(0)) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_check(input logic [1:0] measured, input logic passive,
			input logic [31:0] idle);
		int unsigned gap;
		s_tdata  <= {{(acn_pkg::IN_BITS - 34){1'b0}}, idle, measured};
		s_tuser  <= passive;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		notices_due.push_back(predict_notice(measured, passive, idle));
		checks_sent++;
		gap = tx_gaps ? short_or_long(45) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// lower valid and let every word come back before touching config
	task automatic wait_idle();
		if (s_tvalid)
			s_tvalid <= 1'b0;
		wait (notices_due.size() == 0);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(input logic [acn_pkg::INDEX_BITS-1:0] index,
			input logic [15:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		reg_writes++;
		case (index)
			acn_pkg::REG_HOLD_COUNT:  hold_cfg = data;
			acn_pkg::REG_RENOTIFY:    renotify_cfg = data;
			acn_pkg::REG_ESCALATE:    escalate_cfg = data;
			acn_pkg::REG_PASSIVE_TMO: passive_tmo_cfg = data;
			acn_pkg::REG_ACK_ENABLED: ack_en_cfg = data[0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [15:0] hold, input logic [15:0] renot,
			input logic [15:0] esc, input logic [15:0] tmo, input logic ack);
		wait_idle();
		// unused indexes must be ignored
		if ($urandom_range(0, 1))
			write_reg(acn_pkg::INDEX_BITS'($urandom_range(REG_FIRST_UNUSED, 7)),
				16'($urandom));
		write_reg(acn_pkg::REG_HOLD_COUNT, hold);
		write_reg(acn_pkg::REG_RENOTIFY, renot);
		write_reg(acn_pkg::REG_ESCALATE, esc);
		write_reg(acn_pkg::REG_PASSIVE_TMO, tmo);
		// upper data bits are junk for the 1-bit register
		write_reg(acn_pkg::REG_ACK_ENABLED, {15'($urandom), ack});
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	task automatic test_defaults();
		send_check(acn_pkg::SVC_OK, 1'b0, 32'd0);
		send_check(acn_pkg::SVC_WARNING, 1'b1, 32'hFFFF_FFFF);
		send_check(acn_pkg::SVC_CRITICAL, 1'b0, 32'd0);
		send_check(SVC_UNKNOWN, 1'b1, 32'd0);
		send_check(SVC_UNKNOWN, 1'b0, 32'h5555_5555);
		send_check(acn_pkg::SVC_OK, 1'b0, 32'hAAAA_AAAA);
	endtask

	task automatic test_passive_timeout();
		configure(16'd0, 16'd0, 16'd0, 16'd100, 1'b0);
		send_check(acn_pkg::SVC_OK, 1'b1, 32'd99);
		send_check(acn_pkg::SVC_OK, 1'b1, 32'd100);
		send_check(acn_pkg::SVC_OK, 1'b1, 32'd199);
		send_check(acn_pkg::SVC_OK, 1'b1, 32'd200);
		send_check(acn_pkg::SVC_OK, 1'b0, 32'hFFFF_FFFF);
		// doubled timeout no longer fits in 16 bits
		configure(16'd0, 16'd0, 16'd0, 16'd40000, 1'b1);
		send_check(SVC_UNKNOWN, 1'b1, 32'd79999);
		send_check(acn_pkg::SVC_OK, 1'b1, 32'd80000);
		configure(16'd0, 16'd0, 16'd0, COUNT_MAX, 1'b0);
		send_check(acn_pkg::SVC_OK, 1'b1, 32'd131069);
		send_check(acn_pkg::SVC_OK, 1'b1, 32'd131070);
		send_check(acn_pkg::SVC_OK, 1'b1, 32'hFFFF_FFFF);
	endtask

	task automatic test_hold_and_periodic();
		configure(16'd3, 16'd2, 16'd3, 16'd0, 1'b1);
		repeat (8) send_check(acn_pkg::SVC_CRITICAL, 1'b0, 32'd0);
		repeat (4) send_check(acn_pkg::SVC_OK, 1'b0, 32'd0);
		// critical not yet announced, then hold lowered below the count
		configure(16'd5, 16'd0, 16'd0, 16'd0, 1'b1);
		repeat (3) send_check(acn_pkg::SVC_CRITICAL, 1'b0, 32'd0);
		configure(16'd1, 16'd3, 16'd0, 16'd0, 1'b0);
		repeat (2) send_check(acn_pkg::SVC_CRITICAL, 1'b0, 32'd0);
	endtask

	function automatic logic [15:0] pick_period();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return COUNT_MAX;
			2: return 16'd1;
			3: return 16'($urandom);
			default: return 16'($urandom_range(2, 6));
		endcase
	endfunction

	function automatic logic [31:0] pick_idle();
		logic [31:0] t;
		t = {16'd0, passive_tmo_cfg};
		case ($urandom_range(0, 11))
			0: return $urandom;
			1: return 32'd0;
			2: return 32'hFFFF_FFFF;
			3: return t;
			4: return t - 1;
			5: return 2 * t;
			6: return 2 * t - 1;
			default: return (t == 0) ? $urandom_range(0, 1000) : $urandom_range(0, 3 * t);
		endcase
	endfunction

	task automatic test_random_phases();
		logic [1:0] st;
		logic passive;
		int unsigned sent, run;
		for (int phase = 0; phase < 12; phase++) begin
			if (phase == 0)
				configure(COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, 1'b1);
			else if (phase == 11)
				configure(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
			else
				configure($urandom_range(0, 9) == 0 ? pick_period() : 16'($urandom_range(0, 5)),
					pick_period(), pick_period(),
					$urandom_range(0, 3) == 0 ? 16'd0 : pick_period(),
					1'($urandom));
			tx_gaps = (phase % 4 != 3);
			rx_gaps = (phase % 4 != 2);
			sent = 0;
			while (sent < 150) begin
				// runs of one state so the hold count is reached
				st = 2'($urandom);
				passive = ($urandom_range(0, 3) == 0);
				run = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
				for (int k = 0; k < run; k++) begin
					if ($urandom_range(0, 9) == 0)
						send_check(2'($urandom), 1'($urandom), $urandom);
					else
						send_check(st, passive, pick_idle());
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = acn_pkg::REG_HOLD_COUNT;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		tx_gaps   = 1'b1;
		rx_gaps   = 1'b1;
		cycles    = 0;
		clear_service_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_passive_timeout();
		test_hold_and_periodic();
		test_random_phases();
		wait_idle();

		$display("%0d check results across %0d configurations (%0d register writes)",
			checks_sent, settings_used, reg_writes);
		$display("words with notify %0d, renotify %0d, escalate %0d; %0d mismatches",
			notify_seen, renotify_seen, escalate_seen, fails);
		if (fails == 0 && notices_due.size() == 0)
			$display("alert_notify_state_machine test passed");
		else
			$display("alert_notify_state_machine test failed");
		$finish;
	end

endmodule
